// ===== hw/rtl/rlp_pkg.sv =====
package rlp_pkg;

  // Default geometry of the pattern generator.
  localparam int unsigned PwmPeriodSteps = 16;
  localparam int unsigned FadeTicks      = 2000;

  // Blink timing in ticks.
  localparam int unsigned HalfFast   = 250;
  localparam int unsigned PeriodFast = 500;
  localparam int unsigned HalfSlow   = 500;
  localparam int unsigned PeriodSlow = 1000;
  localparam int unsigned PhaseW     = $clog2(PeriodSlow);

  localparam int unsigned DutyW = 5;

  // Register reset values.
  localparam logic [DutyW-1:0] DutyRedMax    = 5'd8;
  localparam logic [DutyW-1:0] DutyGreenMax  = 5'd2;
  localparam logic [DutyW-1:0] DutyBlueMax   = 5'd4;
  localparam logic [DutyW-1:0] DutyGreenOrng = 5'd1;

  typedef enum logic [1:0] {
    REG_RED_MAX      = 2'd0,
    REG_GREEN_MAX    = 2'd1,
    REG_BLUE_MAX     = 2'd2,
    REG_GREEN_ORANGE = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ACT_TICK      = 1'b0,
    ACT_FORCE_OFF = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    MODE_OFF          = 4'd0,
    MODE_WHITE_PULSE  = 4'd1,
    MODE_WHITE_FADE   = 4'd2,
    MODE_WHITE_ORANGE = 4'd3,
    MODE_YELLOW       = 4'd4,
    MODE_YELLOW_BLINK = 4'd5,
    MODE_GREEN        = 4'd6,
    MODE_RED          = 4'd7,
    MODE_RED_BLINK    = 4'd8,
    MODE_NONE         = 4'd15
  } mode_e;

  typedef struct packed {
    logic [DutyW-1:0] red_max;
    logic [DutyW-1:0] green_max;
    logic [DutyW-1:0] blue_max;
    logic [DutyW-1:0] green_orange;
  } led_cfg_t;

  typedef struct packed {
    action_e    action;
    logic [3:0] mode;
  } led_item_t;

  typedef struct packed {
    logic strobe;
    logic blue;
    logic green;
    logic red;
  } led_res_t;

endpackage

// ===== hw/rtl/rlp_cfg_regs.sv =====
module rlp_cfg_regs import rlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [DutyW-1:0] cfg_data_i,
  output led_cfg_t         cfg_o
);

  led_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RED_MAX:      cfg_d.red_max      = cfg_data_i;
        REG_GREEN_MAX:    cfg_d.green_max    = cfg_data_i;
        REG_BLUE_MAX:     cfg_d.blue_max     = cfg_data_i;
        REG_GREEN_ORANGE: cfg_d.green_orange = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_max      <= DutyRedMax;
      cfg_q.green_max    <= DutyGreenMax;
      cfg_q.blue_max     <= DutyBlueMax;
      cfg_q.green_orange <= DutyGreenOrng;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/rlp_pattern.sv =====
module rlp_pattern import rlp_pkg::*; #(
  parameter int unsigned PWM_PERIOD_STEPS = PwmPeriodSteps,
  parameter int unsigned FADE_TICKS       = FadeTicks
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  led_item_t item_i,
  input  led_cfg_t  cfg_i,
  output led_res_t  res_o
);

  localparam int unsigned StepW = (PWM_PERIOD_STEPS > 1) ? $clog2(PWM_PERIOD_STEPS) : 1;
  localparam int unsigned LeftW = $clog2(FADE_TICKS + 1);
  localparam int unsigned IncW  = $clog2(PWM_PERIOD_STEPS + 1);
  localparam int unsigned ProdW = DutyW + LeftW;
  localparam int unsigned ThrW  = IncW + LeftW;
  localparam int unsigned CmpW  = (ProdW > ThrW) ? ProdW : ThrW;
  localparam int unsigned DcmpW = (StepW > DutyW) ? StepW : DutyW;

  localparam logic [StepW-1:0]  StepLast  = StepW'(PWM_PERIOD_STEPS - 1);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(PeriodSlow - 1);
  localparam logic [LeftW-1:0]  LeftFull  = LeftW'(FADE_TICKS);

  logic [3:0]        mode_d, mode_q;
  logic [StepW-1:0]  step_d, step_q;
  logic [PhaseW-1:0] phase_d, phase_q, phase;
  logic [LeftW-1:0]  left_d, left_q, left;
  logic [2:0]        last_d, last_q;

  logic              restart, fast_lit, slow_lit;
  logic              on_r, on_g, on_b, on_go;
  logic              fade_r, fade_g, fade_b;
  logic [CmpW-1:0]   thr;
  logic [2:0]        rgb;

  assign restart = (item_i.mode != mode_q);
  assign phase   = restart ? '0 : phase_q;
  assign left    = restart ? LeftFull : left_q;

  // Fast blink: lit in the first half of each 500-tick period.
  assign fast_lit = (phase < PhaseW'(HalfFast)) ||
                    ((phase >= PhaseW'(PeriodFast)) &&
                     (phase < PhaseW'(PeriodFast + HalfFast)));
  assign slow_lit = (phase < PhaseW'(HalfSlow));

  assign on_r  = DcmpW'(step_q) < DcmpW'(cfg_i.red_max);
  assign on_g  = DcmpW'(step_q) < DcmpW'(cfg_i.green_max);
  assign on_b  = DcmpW'(step_q) < DcmpW'(cfg_i.blue_max);
  assign on_go = DcmpW'(step_q) < DcmpW'(cfg_i.green_orange);

  // The scaled duty floor(duty * left / F) exceeds the step exactly when
  // duty * left reaches (step + 1) * F, which avoids any division.
  assign thr    = CmpW'(CmpW'(step_q) + CmpW'(1)) * CmpW'(FADE_TICKS);
  assign fade_r = (CmpW'(cfg_i.red_max)   * CmpW'(left)) >= thr;
  assign fade_g = (CmpW'(cfg_i.green_max) * CmpW'(left)) >= thr;
  assign fade_b = (CmpW'(cfg_i.blue_max)  * CmpW'(left)) >= thr;

  always_comb begin
    rgb = 3'b000;
    case (mode_e'(item_i.mode))
      MODE_WHITE_PULSE:  rgb = fast_lit ? {on_b, on_g, on_r} : 3'b000;
      MODE_WHITE_FADE:   rgb = (left != '0) ? {fade_b, fade_g, fade_r} : 3'b000;
      MODE_WHITE_ORANGE: rgb = fast_lit ? {on_b, on_g, on_r} : {1'b0, on_go, on_r};
      MODE_YELLOW:       rgb = {1'b0, on_g, on_r};
      MODE_YELLOW_BLINK: rgb = slow_lit ? {1'b0, on_g, on_r} : 3'b000;
      MODE_GREEN:        rgb = {1'b0, on_g, 1'b0};
      MODE_RED:          rgb = {2'b00, on_r};
      MODE_RED_BLINK:    rgb = slow_lit ? {2'b00, on_r} : 3'b000;
      default:           rgb = 3'b000;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    step_d  = step_q;
    phase_d = phase_q;
    left_d  = left_q;
    last_d  = last_q;
    if (item_i.action == ACT_FORCE_OFF) begin
      res_o  = '{strobe: 1'b1, blue: 1'b0, green: 1'b0, red: 1'b0};
      last_d = 3'b000;
    end else begin
      res_o   = '{strobe: (rgb != last_q), blue: rgb[2], green: rgb[1], red: rgb[0]};
      last_d  = rgb;
      mode_d  = item_i.mode;
      step_d  = (step_q == StepLast) ? '0 : step_q + StepW'(1);
      phase_d = (phase == PhaseLast) ? '0 : phase + PhaseW'(1);
      left_d  = (left != '0) ? left - LeftW'(1) : left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      step_q  <= '0;
      phase_q <= '0;
      left_q  <= LeftFull;
      last_q  <= 3'b000;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      last_q  <= last_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast) else $error("PWM step beyond its period");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast) else $error("Blink phase beyond its period");

  a_force_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (item_i.action == ACT_FORCE_OFF) |=> (last_q == 3'b000))
    else $error("Force off did not clear the last written levels");

endmodule

// ===== hw/rtl/rgb_led_pattern_pwm_unit.sv =====
// RGB LED pattern generator. Each input transaction is either a 1 ms tick
// carrying the requested pattern mode or a force-off request, and gives exactly
// one output transaction holding the three LED line levels and a write strobe
// that is set when the levels differ from those last written, and always on a
// force-off. The block takes one transaction per clock cycle while the output is
// not stalled; each result passes through the input register and then the
// result register, which sit around the pattern logic, before it is valid on
// the output. Duty caps are written through the configuration channel,
// which is always ready and should only be used while no transaction is in
// flight.
module rgb_led_pattern_pwm_unit import rlp_pkg::*; #(
  parameter int unsigned PWM_PERIOD_STEPS = PwmPeriodSteps,
  parameter int unsigned FADE_TICKS       = FadeTicks
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [3:0] mode, [7:4] zero
  input  logic             s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] red_on, [1] green_on,
                                           // [2] blue_on, [3] write_strobe
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [DutyW-1:0] cfg_data_i
);

  led_cfg_t  cfg;
  led_item_t item_q;
  led_res_t  res, res_q;
  logic      in_vld_q, out_vld_q, adv;

  rlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The pattern stage moves when it holds a transaction and the result register is free or drains.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.action <= action_e'(s_axis_tuser);
      item_q.mode   <= s_axis_tdata[3:0];
    end
  end

  rlp_pattern #(
    .PWM_PERIOD_STEPS (PWM_PERIOD_STEPS),
    .FADE_TICKS       (FADE_TICKS)
  ) u_pattern (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_q.strobe, res_q.blue, res_q.green, res_q.red};

  a_force_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (item_q.action == ACT_FORCE_OFF) |=>
      (res_q.strobe && !res_q.red && !res_q.green && !res_q.blue))
    else $error("Force off result is not a blank write");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |-> !s_axis_tready)
    else $error("Input register accepts while holding a stalled transaction");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("Processed transaction did not reach the result register");

endmodule

// ===== tb/rgb_led_pattern_pwm_unit_tb.sv =====
`timescale 1ns / 100ps

module rgb_led_pattern_pwm_unit_tb;
  import rlp_pkg::*;

  localparam int unsigned FadeW      = $clog2(FadeTicks + 1);
  localparam int unsigned CycleLimit = 400000;

  class led_pattern_scoreboard;
    logic [DutyW-1:0]  red_max;
    logic [DutyW-1:0]  green_max;
    logic [DutyW-1:0]  blue_max;
    logic [DutyW-1:0]  green_orange;
    logic [3:0]        cur_mode;
    logic [3:0]        pwm_pos;
    logic [PhaseW-1:0] phase;
    logic [FadeW-1:0]  fade_ms;
    logic [2:0]        last_lvl;
    led_res_t          led_levels_q[$];
    int                errors;

    function new();
      red_max      = DutyRedMax;
      green_max    = DutyGreenMax;
      blue_max     = DutyBlueMax;
      green_orange = DutyGreenOrng;
      cur_mode     = MODE_NONE;
      pwm_pos      = '0;
      phase        = '0;
      fade_ms      = '0;
      last_lvl     = '0;
      errors       = 0;
    endfunction

    function void set_duty(reg_idx_e idx, logic [DutyW-1:0] val);
      case (idx)
        REG_RED_MAX:      red_max = val;
        REG_GREEN_MAX:    green_max = val;
        REG_BLUE_MAX:     blue_max = val;
        REG_GREEN_ORANGE: green_orange = val;
        default:          ;
      endcase
    endfunction

    function logic lane_on(logic [DutyW-1:0] duty);
      return (duty != '0) && ({1'b0, pwm_pos} < duty);
    endfunction

    function void note_input(action_e act, logic [3:0] md);
      led_res_t         res;
      logic [DutyW-1:0] dr;
      logic [DutyW-1:0] dg;
      logic [DutyW-1:0] db;
      logic             lit;
      int unsigned      ramp_left;
      res = '0;
      if (act == ACT_FORCE_OFF) begin
        // Force-off leaves the pattern counters and the mode alone.
        last_lvl   = '0;
        res.strobe = 1'b1;
        led_levels_q.push_back(res);
        return;
      end
      if (md != cur_mode) begin
        cur_mode = md;
        phase    = '0;
        fade_ms  = '0;
      end
      dr  = '0;
      dg  = '0;
      db  = '0;
      lit = 1'b1;
      case (md)
        MODE_WHITE_PULSE: begin
          dr  = red_max;
          dg  = green_max;
          db  = blue_max;
          lit = (phase % PeriodFast) < HalfFast;
        end
        MODE_WHITE_FADE: begin
          if (fade_ms < FadeTicks) begin
            ramp_left = FadeTicks - fade_ms;
            dr = DutyW'((red_max * ramp_left) / FadeTicks);
            dg = DutyW'((green_max * ramp_left) / FadeTicks);
            db = DutyW'((blue_max * ramp_left) / FadeTicks);
          end else begin
            lit = 1'b0;
          end
        end
        MODE_WHITE_ORANGE: begin
          dr = red_max;
          if ((phase % PeriodFast) < HalfFast) begin
            dg = green_max;
            db = blue_max;
          end else begin
            dg = green_orange;
          end
        end
        MODE_YELLOW: begin
          dr = red_max;
          dg = green_max;
        end
        MODE_YELLOW_BLINK: begin
          dr  = red_max;
          dg  = green_max;
          lit = phase < HalfSlow;
        end
        MODE_GREEN: dg = green_max;
        MODE_RED:   dr = red_max;
        MODE_RED_BLINK: begin
          dr  = red_max;
          lit = phase < HalfSlow;
        end
        default: lit = 1'b0;
      endcase
      if (lit) begin
        res.red   = lane_on(dr);
        res.green = lane_on(dg);
        res.blue  = lane_on(db);
      end
      res.strobe = ({res.blue, res.green, res.red} != last_lvl);
      if (res.strobe) last_lvl = {res.blue, res.green, res.red};
      pwm_pos = (pwm_pos == PwmPeriodSteps - 1) ? '0 : pwm_pos + 1'b1;
      phase   = (phase == PeriodSlow - 1) ? '0 : phase + 1'b1;
      if (fade_ms < FadeTicks) fade_ms = fade_ms + 1'b1;
      led_levels_q.push_back(res);
    endfunction

    function void check_result(logic [7:0] data);
      led_res_t want;
      led_res_t got;
      got = led_res_t'(data[3:0]);
      if (led_levels_q.size() == 0) begin
        if (errors < 10) $display("unexpected LED transaction, tdata %02h", data);
        errors++;
        return;
      end
      want = led_levels_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.strobe !== want.strobe || data[7:4] !== 4'b0000) begin
        if (errors < 10) begin
          $display("LED mismatch at %0t: expected r%0b g%0b b%0b strobe %0b, got tdata %02h",
                   $realtime, want.red, want.green, want.blue, want.strobe, data);
        end
        errors++;
      end
    endfunction

    function int pending();
      return led_levels_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [DutyW-1:0] cfg_data_i = '0;

  led_pattern_scoreboard sb = new();
  int burst_left = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  int stall_style = 0;

  rgb_led_pattern_pwm_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver switches between always ready, a coin toss and mostly stalled.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic push_item(input action_e act, input logic [3:0] md);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, md};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, md);
  endtask

  // Holds one mode for a long stretch, with the odd force-off mixed in.
  task automatic run_mode(input logic [3:0] md, input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) == 0) push_item(ACT_FORCE_OFF, 4'($urandom_range(0, 15)));
      else push_item(ACT_TICK, md);
    end
  endtask

  task automatic random_patterns(input int n);
    logic [3:0] md;
    int         run_len;
    while (n > 0) begin
      md      = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8))
                                          : 4'($urandom_range(9, 15));
      run_len = $urandom_range(1, 30);
      for (int k = 0; k < run_len && n > 0; k++) begin
        if ($urandom_range(0, 24) == 0) push_item(ACT_FORCE_OFF, 4'($urandom_range(0, 15)));
        else push_item(ACT_TICK, md);
        n--;
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DutyW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_duty(idx, val);
  endtask

  task automatic write_duties(input logic [DutyW-1:0] r, input logic [DutyW-1:0] g,
                              input logic [DutyW-1:0] b, input logic [DutyW-1:0] o);
    write_reg(REG_RED_MAX, r);
    write_reg(REG_GREEN_MAX, g);
    write_reg(REG_BLUE_MAX, b);
    write_reg(REG_GREEN_ORANGE, o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks with the reset mode value must not restart the phases.
    push_item(ACT_TICK, MODE_NONE);
    push_item(ACT_TICK, MODE_NONE);
    for (int m = MODE_OFF; m <= MODE_RED_BLINK; m++) push_item(ACT_TICK, 4'(m));
    push_item(ACT_FORCE_OFF, MODE_RED);
    push_item(ACT_TICK, MODE_RED_BLINK);
    for (int m = MODE_RED_BLINK + 1; m < MODE_NONE; m++) push_item(ACT_TICK, 4'(m));
    push_item(ACT_FORCE_OFF, MODE_NONE);
    push_item(ACT_FORCE_OFF, MODE_OFF);
    push_item(ACT_TICK, MODE_NONE);

    // A run long enough to cross from white to orange in the fast blink.
    run_mode(MODE_WHITE_ORANGE, HalfFast + 10);

    drain();
    write_duties(5'd31, 5'd16, 5'd31, 5'd17);
    run_mode(MODE_WHITE_FADE, 30);

    drain();
    write_duties(5'd0, 5'd0, 5'd0, 5'd0);
    random_patterns(18);
    drain();
    write_duties(5'd16, 5'd16, 5'd16, 5'd16);
    random_patterns(18);
    drain();
    write_duties(5'd1, 5'd15, 5'd17, 5'd31);
    random_patterns(18);
    drain();
    write_duties(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    random_patterns(18);
    drain();
    write_duties(DutyRedMax, DutyGreenMax, DutyBlueMax, DutyGreenOrng);
    random_patterns(18);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
